### sv/dto_pkg.sv
// Shared types and codes for the dependency topological order block.
package dto_pkg;

  // Field widths of the input and result words.
  localparam int OPCODE_W = 2;
  localparam int COUNT_W  = 7;
  localparam int VERTEX_W = 6;
  localparam int STATUS_W = 2;

  // Item opcodes.
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_BUILD = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ORDERED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CYCLE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd3;

  // Input word.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COUNT_W-1:0]  vertex_count;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_word_t;

endpackage

### sv/dto_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module dto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read in one clocked block; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/dto_seq.sv
// Sequencer that loads the graph, walks it depth-first and reads out the order.
module dto_seq #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  dto_pkg::in_word_t  in_word,
  output logic               in_stall,
  output logic               res_valid,
  output dto_pkg::out_word_t res_word,
  input  logic               res_take
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int PW  = EW + 1;
  localparam logic [PW-1:0] LIST_END = PW'(MAX_EDGES);

  typedef enum logic [3:0] {
    S_IDLE, S_LINK, S_ROOT, S_HEAD, S_STEP, S_EDGE, S_POPW, S_ORD_RD, S_ORD_WR, S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           active_r, active_nxt;
  logic [PW-1:0]           edges_r, edges_nxt;
  logic [CW-1:0]           order_len_r, order_len_nxt;
  logic [MAX_VERTICES-1:0] list_used_r, list_used_nxt;
  logic [MAX_VERTICES-1:0] has_parent_r, has_parent_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] on_stack_r, on_stack_nxt;
  logic [CW-1:0]           sp_r, sp_nxt;
  logic [CW-1:0]           scan_r, scan_nxt;
  logic [CW-1:0]           k_r, k_nxt;
  logic [VIW-1:0]          top_v_r, top_v_nxt;
  logic [PW-1:0]           top_c_r, top_c_nxt;
  logic [EW-1:0]           link_e_r, link_e_nxt;
  dto_pkg::out_word_t      pend_r, pend_nxt;

  // Memory ports.
  logic           tgt_we, tgt_re;
  logic [EW-1:0]  tgt_waddr, tgt_raddr;
  logic [VIW-1:0] tgt_wdata, tgt_rdata;
  logic           nxt_we, nxt_re;
  logic [EW-1:0]  nxt_waddr, nxt_raddr;
  logic [PW-1:0]  nxt_wdata, nxt_rdata;
  logic           head_we, head_re;
  logic [VIW-1:0] head_waddr, head_raddr;
  logic [EW-1:0]  head_wdata, head_rdata;
  logic           tail_we, tail_re;
  logic [VIW-1:0] tail_waddr, tail_raddr;
  logic [EW-1:0]  tail_wdata, tail_rdata;
  logic           stk_we, stk_re;
  logic [VIW-1:0] stk_waddr, stk_raddr;
  logic [VIW+PW-1:0] stk_wdata, stk_rdata;
  logic           ord_we, ord_re;
  logic [VIW-1:0] ord_waddr, ord_raddr;
  logic [VIW-1:0] ord_wdata, ord_rdata;

  // Decode helpers.
  logic [CW-1:0]  count_sat;
  logic           add_reject;
  logic [VIW-1:0] f_idx, t_idx, w_idx, scan_idx;
  logic           ord_last;

  // Edge target store.
  dto_ram #(.WIDTH(VIW), .DEPTH(MAX_EDGES)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
    .re(tgt_re), .raddr(tgt_raddr), .rdata(tgt_rdata)
  );

  // Edge next-pointer store.
  dto_ram #(.WIDTH(PW), .DEPTH(MAX_EDGES)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .re(nxt_re), .raddr(nxt_raddr), .rdata(nxt_rdata)
  );

  // Per-vertex list heads.
  dto_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
  );

  // Per-vertex list tails.
  dto_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .re(tail_re), .raddr(tail_raddr), .rdata(tail_rdata)
  );

  // Walk stack below the top entry: vertex and edge cursor.
  dto_ram #(.WIDTH(VIW + PW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Post-order record.
  dto_ram #(.WIDTH(VIW), .DEPTH(MAX_VERTICES)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .re(ord_re), .raddr(ord_raddr), .rdata(ord_rdata)
  );

  // Field decode for the item at the input.
  always_comb begin
    count_sat = (in_word.vertex_count > dto_pkg::COUNT_W'(MAX_VERTICES)) ?
                CW'(MAX_VERTICES) : CW'(in_word.vertex_count);
    add_reject = ({1'b0, in_word.from_vertex} >= dto_pkg::COUNT_W'(active_r)) ||
                 ({1'b0, in_word.to_vertex} >= dto_pkg::COUNT_W'(active_r)) ||
                 (edges_r == LIST_END);
    f_idx    = in_word.from_vertex[VIW-1:0];
    t_idx    = in_word.to_vertex[VIW-1:0];
    w_idx    = tgt_rdata;
    scan_idx = scan_r[VIW-1:0];
    ord_last = (CW'(k_r + 1'b1) == order_len_r);
  end

  // Next-state and memory control.
  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    edges_nxt      = edges_r;
    order_len_nxt  = order_len_r;
    list_used_nxt  = list_used_r;
    has_parent_nxt = has_parent_r;
    visited_nxt    = visited_r;
    on_stack_nxt   = on_stack_r;
    sp_nxt         = sp_r;
    scan_nxt       = scan_r;
    k_nxt          = k_r;
    top_v_nxt      = top_v_r;
    top_c_nxt      = top_c_r;
    link_e_nxt     = link_e_r;
    pend_nxt       = pend_r;

    tgt_we = 1'b0;  tgt_waddr = edges_r[EW-1:0];  tgt_wdata = t_idx;
    tgt_re = 1'b0;  tgt_raddr = top_c_r[EW-1:0];
    nxt_we = 1'b0;  nxt_waddr = edges_r[EW-1:0];  nxt_wdata = LIST_END;
    nxt_re = 1'b0;  nxt_raddr = top_c_r[EW-1:0];
    head_we = 1'b0; head_waddr = f_idx;           head_wdata = edges_r[EW-1:0];
    head_re = 1'b0; head_raddr = scan_idx;
    tail_we = 1'b0; tail_waddr = f_idx;           tail_wdata = edges_r[EW-1:0];
    tail_re = 1'b0; tail_raddr = f_idx;
    stk_we = 1'b0;  stk_waddr = VIW'(sp_r - 1'b1); stk_wdata = {top_v_r, nxt_rdata};
    stk_re = 1'b0;  stk_raddr = VIW'(sp_r - 2'd2);
    ord_we = 1'b0;  ord_waddr = order_len_r[VIW-1:0]; ord_wdata = top_v_r;
    ord_re = 1'b0;  ord_raddr = k_r[VIW-1:0];

    res_valid = 1'b0;
    res_word  = pend_r;

    case (state_r)
      // Take one item and dispatch on its opcode.
      S_IDLE: begin
        if (in_valid) begin
          case (in_word.opcode)
            dto_pkg::OP_CLEAR: begin
              active_nxt     = count_sat;
              edges_nxt      = '0;
              order_len_nxt  = '0;
              list_used_nxt  = '0;
              has_parent_nxt = '0;
              visited_nxt    = '0;
              on_stack_nxt   = '0;
            end
            dto_pkg::OP_ADD: begin
              if (add_reject) begin
                pend_nxt  = '{vertex: '0, status: dto_pkg::ST_REJECT, last: 1'b1};
                state_nxt = S_EMIT;
              end else begin
                tgt_we  = 1'b1;
                nxt_we  = 1'b1;
                tail_we = 1'b1;
                if (list_used_r[f_idx]) begin
                  // Append behind the current tail once its index is read.
                  tail_re    = 1'b1;
                  link_e_nxt = edges_r[EW-1:0];
                  state_nxt  = S_LINK;
                end else begin
                  head_we              = 1'b1;
                  list_used_nxt[f_idx] = 1'b1;
                end
                edges_nxt             = edges_r + 1'b1;
                has_parent_nxt[t_idx] = 1'b1;
              end
            end
            dto_pkg::OP_BUILD: begin
              visited_nxt   = '0;
              on_stack_nxt  = '0;
              order_len_nxt = '0;
              scan_nxt      = '0;
              sp_nxt        = '0;
              state_nxt     = S_ROOT;
            end
            default: begin
            end
          endcase
        end
      end

      // Link the old tail edge to the new edge.
      S_LINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_rdata;
        nxt_wdata = {1'b0, link_e_r};
        state_nxt = S_IDLE;
      end

      // Scan vertices in index order for the next unvisited root.
      S_ROOT: begin
        if (scan_r == active_r) begin
          if (order_len_r == '0) begin
            pend_nxt  = '{vertex: '0, status: dto_pkg::ST_EMPTY, last: 1'b1};
            state_nxt = S_EMIT;
          end else begin
            k_nxt     = '0;
            state_nxt = S_ORD_RD;
          end
        end else if (!has_parent_r[scan_idx] && !visited_r[scan_idx]) begin
          visited_nxt[scan_idx]  = 1'b1;
          on_stack_nxt[scan_idx] = 1'b1;
          top_v_nxt              = scan_idx;
          head_re                = 1'b1;
          state_nxt              = S_HEAD;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // The pushed vertex's list head arrives; it becomes the top cursor.
      S_HEAD: begin
        top_c_nxt = list_used_r[top_v_r] ? {1'b0, head_rdata} : LIST_END;
        sp_nxt    = sp_r + 1'b1;
        state_nxt = S_STEP;
      end

      // Either retire the top vertex or fetch its next edge.
      S_STEP: begin
        if (top_c_r == LIST_END) begin
          on_stack_nxt[top_v_r] = 1'b0;
          ord_we                = 1'b1;
          order_len_nxt         = order_len_r + 1'b1;
          if (sp_r == CW'(1)) begin
            sp_nxt    = '0;
            scan_nxt  = scan_r + 1'b1;
            state_nxt = S_ROOT;
          end else begin
            stk_re    = 1'b1;
            sp_nxt    = sp_r - 1'b1;
            state_nxt = S_POPW;
          end
        end else begin
          tgt_re    = 1'b1;
          nxt_re    = 1'b1;
          state_nxt = S_EDGE;
        end
      end

      // Examine the edge target: descend, report a cycle, or skip.
      S_EDGE: begin
        top_c_nxt = nxt_rdata;
        if (!visited_r[w_idx]) begin
          visited_nxt[w_idx]  = 1'b1;
          on_stack_nxt[w_idx] = 1'b1;
          stk_we              = 1'b1;
          top_v_nxt           = w_idx;
          head_re             = 1'b1;
          head_raddr          = w_idx;
          state_nxt           = S_HEAD;
        end else if (on_stack_r[w_idx]) begin
          pend_nxt  = '{vertex: '0, status: dto_pkg::ST_CYCLE, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_STEP;
        end
      end

      // Restore the parent entry as the new top.
      S_POPW: begin
        top_v_nxt = stk_rdata[VIW+PW-1:PW];
        top_c_nxt = stk_rdata[PW-1:0];
        state_nxt = S_STEP;
      end

      // Read the next recorded vertex.
      S_ORD_RD: begin
        ord_re    = 1'b1;
        state_nxt = S_ORD_WR;
      end

      // Offer it as a result; the read data holds until it is taken.
      S_ORD_WR: begin
        res_valid = 1'b1;
        res_word  = '{vertex: dto_pkg::VERTEX_W'(ord_rdata),
                      status: dto_pkg::ST_ORDERED, last: ord_last};
        if (res_take) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ord_last ? S_IDLE : S_ORD_RD;
        end
      end

      // Offer a single status result.
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      edges_r      <= '0;
      order_len_r  <= '0;
      list_used_r  <= '0;
      has_parent_r <= '0;
      visited_r    <= '0;
      on_stack_r   <= '0;
      sp_r         <= '0;
      scan_r       <= '0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      edges_r      <= edges_nxt;
      order_len_r  <= order_len_nxt;
      list_used_r  <= list_used_nxt;
      has_parent_r <= has_parent_nxt;
      visited_r    <= visited_nxt;
      on_stack_r   <= on_stack_nxt;
      sp_r         <= sp_nxt;
      scan_r       <= scan_nxt;
      k_r          <= k_nxt;
    end
    top_v_r  <= top_v_nxt;
    top_c_r  <= top_c_nxt;
    link_e_r <= link_e_nxt;
    pend_r   <= pend_nxt;
  end

endmodule

### sv/dependency_topological_order.sv
// Top level of the dependency topological order block with its output register.
//
//   Channel | Ports                          | Word
//   --------+--------------------------------+---------------------
//   input   | in_valid, in_stall, in_word    | dto_pkg::in_word_t
//   result  | out_valid, out_stall, out_word | dto_pkg::out_word_t
//
// Clear and unused items and an accepted edge finish in the idle state; an edge
// appended behind an existing list tail also passes the link state, and a rejected
// edge waits for its result slot. A build walks the graph with the single-step
// sequencer and registered edge and stack memory reads, then reads and offers each
// ordered result. Reset is synchronous and clears all control state.
// in_stall is high whenever an item is in work; out_stall only delays result delivery.
module dependency_topological_order #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  dto_pkg::in_word_t  in_word,
  output logic               in_stall,
  output logic               out_valid,
  output dto_pkg::out_word_t out_word,
  input  logic               out_stall
);

  logic               res_valid;
  logic               res_take;
  dto_pkg::out_word_t res_word;
  logic               out_valid_r, out_valid_nxt;
  dto_pkg::out_word_t out_word_r;

  dto_seq #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .res_valid(res_valid),
    .res_word (res_word),
    .res_take (res_take)
  );

  // A result moves into the output register when it is empty or being drained.
  always_comb begin
    res_take      = res_valid && (!out_valid_r || !out_stall);
    out_valid_nxt = res_take || (out_valid_r && out_stall);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### sv/dto_checker.sv
// Port-level checker for the dependency topological order block and its bind.
module dto_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input dto_pkg::in_word_t  in_word,
  input logic               in_stall,
  input logic               out_valid,
  input dto_pkg::out_word_t out_word,
  input logic               out_stall
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Status results carry vertex zero and end their item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != dto_pkg::ST_ORDERED) |->
      out_word.last && (out_word.vertex == '0))
    else $error("status result not marked last or vertex not zero");

  // A clear item finishes at once and gives no result.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.opcode == dto_pkg::OP_CLEAR) && !out_valid |=>
      !in_stall && !out_valid)
    else $error("clear item produced a result or held the input");

  // A build keeps the input stalled in the following cycle.
  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.opcode == dto_pkg::OP_BUILD) |=> in_stall)
    else $error("input not stalled after a build item");

endmodule

bind dependency_topological_order dto_checker u_dto_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_word  (in_word),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_word (out_word),
  .out_stall(out_stall)
);

### tb/testbench.sv
// Self-checking testbench for the dependency topological order block.
module testbench;

  localparam int GRAPH_VERTS  = 64;
  localparam int EDGE_SLOTS   = 256;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int CHUNK_WORDS  = 18;
  localparam logic [1:0] NO_OPCODE = 2'd3;

  // Idling phases of the random part.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_phase_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  dto_pkg::in_word_t  in_word = '0;
  logic               in_stall;
  logic               out_valid;
  dto_pkg::out_word_t out_word;
  logic               out_stall = 1'b0;

  // Words waiting to be sent and results waiting to arrive.
  dto_pkg::in_word_t  graph_cmds[$];
  dto_pkg::out_word_t awaited_results[$];

  // Shadow copy of the graph, kept in step with accepted words.
  logic [5:0] dep_target [EDGE_SLOTS];
  int         dep_next   [EDGE_SLOTS];
  int         dep_head   [GRAPH_VERTS];
  int         dep_tail   [GRAPH_VERTS];
  bit         dep_needed [GRAPH_VERTS];
  int         live_vertices = 0;
  int         links_used = 0;

  // Idling knobs, hold-off bookkeeping and run statistics.
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int words_sent = 0;
  int queued_items = 0;
  int graphs_built = 0;
  int results_seen [4];

  dependency_topological_order #(
    .MAX_VERTICES(GRAPH_VERTS),
    .MAX_EDGES   (EDGE_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_word (out_word),
    .out_stall(out_stall)
  );

  // Clock and a single synchronous reset pulse.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void expect_result(logic [5:0] v, logic [1:0] s, logic l);
    dto_pkg::out_word_t r;
    r.vertex = v;
    r.status = s;
    r.last   = l;
    awaited_results = {awaited_results, r};
  endfunction

  // Applies one accepted word to the shadow graph and queues the results it causes.
  function automatic void predict_graph_item(dto_pkg::in_word_t w);
    int n, f, t, e, r, sp, top, v, c, nxt;
    bit looped;
    bit seen [GRAPH_VERTS];
    bit open_v [GRAPH_VERTS];
    int st_v [GRAPH_VERTS];
    int st_c [GRAPH_VERTS];
    int order_q[$];
    case (w.opcode)
      dto_pkg::OP_CLEAR: begin
        n = int'(w.vertex_count);
        live_vertices = (n > GRAPH_VERTS) ? GRAPH_VERTS : n;
        links_used = 0;
        for (v = 0; v < GRAPH_VERTS; v++) begin
          dep_head[v]   = EDGE_SLOTS;
          dep_tail[v]   = EDGE_SLOTS;
          dep_needed[v] = 1'b0;
        end
      end
      dto_pkg::OP_ADD: begin
        f = int'(w.from_vertex);
        t = int'(w.to_vertex);
        if (f >= live_vertices || t >= live_vertices || links_used >= EDGE_SLOTS) begin
          expect_result('0, dto_pkg::ST_REJECT, 1'b1);
        end else begin
          e = links_used;
          links_used++;
          dep_target[e] = 6'(t);
          dep_next[e]   = EDGE_SLOTS;
          if (dep_head[f] >= EDGE_SLOTS) dep_head[f] = e;
          else dep_next[dep_tail[f]] = e;
          dep_tail[f]   = e;
          dep_needed[t] = 1'b1;
        end
      end
      dto_pkg::OP_BUILD: begin
        looped = 1'b0;
        for (v = 0; v < GRAPH_VERTS; v++) begin
          seen[v]   = 1'b0;
          open_v[v] = 1'b0;
        end
        // Depth-first walk from each root, post-order recording.
        for (r = 0; r < live_vertices && !looped; r++) begin
          if (!dep_needed[r] && !seen[r]) begin
            seen[r]   = 1'b1;
            open_v[r] = 1'b1;
            st_v[0]   = r;
            st_c[0]   = dep_head[r];
            sp        = 1;
            while (sp > 0 && !looped) begin
              top = sp - 1;
              v   = st_v[top];
              c   = st_c[top];
              if (c >= EDGE_SLOTS) begin
                sp--;
                open_v[v] = 1'b0;
                order_q = {order_q, v};
              end else begin
                nxt       = int'(dep_target[c]);
                st_c[top] = dep_next[c];
                if (!seen[nxt]) begin
                  seen[nxt]   = 1'b1;
                  open_v[nxt] = 1'b1;
                  st_v[sp]    = nxt;
                  st_c[sp]    = dep_head[nxt];
                  sp++;
                end else if (open_v[nxt]) begin
                  looped = 1'b1;
                end
              end
            end
          end
        end
        if (looped) begin
          expect_result('0, dto_pkg::ST_CYCLE, 1'b1);
        end else if (order_q.size() == 0) begin
          expect_result('0, dto_pkg::ST_EMPTY, 1'b1);
        end else begin
          foreach (order_q[i]) expect_result(6'(order_q[i]), dto_pkg::ST_ORDERED,
                                             i == order_q.size() - 1);
        end
      end
      default: ;
    endcase
  endfunction

  // Stimulus helpers; fields an opcode does not use carry random values.
  task automatic push_word(logic [1:0] op, int cnt, int f, int t);
    dto_pkg::in_word_t w;
    w.opcode       = op;
    w.vertex_count = 7'(cnt);
    w.from_vertex  = 6'(f);
    w.to_vertex    = 6'(t);
    graph_cmds = {graph_cmds, w};
    if (op != NO_OPCODE) queued_items++;
  endtask

  task automatic push_clear(int cnt);
    push_word(dto_pkg::OP_CLEAR, cnt, $urandom_range(63, 0), $urandom_range(63, 0));
  endtask

  task automatic push_dep(int f, int t);
    push_word(dto_pkg::OP_ADD, $urandom_range(127, 0), f, t);
  endtask

  task automatic push_build();
    push_word(dto_pkg::OP_BUILD, $urandom_range(127, 0), $urandom_range(63, 0),
              $urandom_range(63, 0));
  endtask

  task automatic push_noise();
    push_word(NO_OPCODE, $urandom_range(127, 0), $urandom_range(63, 0),
              $urandom_range(63, 0));
  endtask

  // One random graph: clear, a burst of mostly dependencies, then one or two builds.
  task automatic queue_random_graph();
    int n, nv, k, a, b, tmp, e, pick;
    bit tangled;
    int perm [GRAPH_VERTS];
    pick = $urandom_range(31, 0);
    if (pick == 0) n = $urandom_range(1, 0);
    else if (pick < 3) n = $urandom_range(127, 65);
    else if (pick < 7) n = $urandom_range(64, 13);
    else n = $urandom_range(12, 2);
    nv = (n > GRAPH_VERTS) ? GRAPH_VERTS : n;
    // A random ranking keeps the well-formed graphs acyclic.
    for (a = 0; a < nv; a++) perm[a] = a;
    for (a = nv - 1; a > 0; a--) begin
      b       = $urandom_range(a, 0);
      tmp     = perm[a];
      perm[a] = perm[b];
      perm[b] = tmp;
    end
    tangled = ($urandom_range(3, 0) == 0);
    k = $urandom_range((nv < 24) ? 2 * nv : 48, 0);
    push_clear(n);
    for (e = 0; e < k; e++) begin
      pick = $urandom_range(15, 0);
      if (pick == 0 || nv == 0) begin
        push_dep($urandom_range(63, 0), $urandom_range(63, 0));
      end else if (pick == 1) begin
        push_noise();
      end else if (pick == 2) begin
        push_build();
      end else if (tangled || nv < 2) begin
        push_dep($urandom_range(nv - 1, 0), $urandom_range(nv - 1, 0));
      end else begin
        a = $urandom_range(nv - 2, 0);
        b = $urandom_range(nv - 1, a + 1);
        push_dep(perm[b], perm[a]);
      end
    end
    push_build();
    graphs_built++;
    if ($urandom_range(3, 0) == 0) push_build();
  endtask

  // Sender pause: every word taken and every expected result seen.
  task automatic wait_drained();
    while (graph_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_idling(idle_phase_t ph);
    sender_idle_pct = (ph == IDLE_SENDER) ? 76 : (ph == IDLE_BOTH) ? 19 : 0;
    stall_pct       = (ph == IDLE_RECEIVER) ? 76 : (ph == IDLE_BOTH) ? 19 : 0;
  endtask

  function automatic void cmp_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: result %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Driver: offers the next word when the channel is free, predicts on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_graph_item(in_word);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (graph_cmds.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          in_word  <= graph_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen[out_word.status]++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual vertex %0d status %0d last %0d",
                   $time, out_word.vertex, out_word.status, out_word.last);
          fail_count++;
        end else begin
          cmp_field("vertex", int'(awaited_results[0].vertex), int'(out_word.vertex));
          cmp_field("status", int'(awaited_results[0].status), int'(out_word.status));
          cmp_field("last", int'(awaited_results[0].last), int'(out_word.last));
          awaited_results.delete(0);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Long receiver hold-off, counted here on request from the stimulus.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words queued and %0d results outstanding",
               $time, graph_cmds.size(), awaited_results.size());
      $display("dependency_topological_order verification failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int base, chunk, i;
    @(posedge rst_n);
    @(negedge clk);
    set_idling(IDLE_NONE);

    // Directed part: empty graph, rejects, saturation, cycles with and without roots.
    push_build();
    push_dep(0, 0);
    push_noise();
    push_clear(127);
    push_dep(63, 0);
    push_dep(0, 63);
    push_build();
    push_clear(3);
    push_dep(0, 1);
    push_dep(1, 1);
    push_dep(2, 3);
    push_dep(3, 0);
    push_build();
    push_clear(2);
    push_dep(1, 0);
    push_build();
    push_build();
    push_dep(0, 1);
    push_build();
    push_clear(0);
    push_build();
    push_clear(64);
    push_dep(0, 63);
    push_build();
    wait_drained();

    // Fill the dependency store, then hold the receiver while results pile up.
    push_clear(64);
    for (i = 0; i < EDGE_SLOTS; i++) begin
      base = $urandom_range(63, 1);
      push_dep(base, $urandom_range(base - 1, 0));
    end
    wait_drained();
    hold_requests++;
    push_build();
    push_dep($urandom_range(63, 0), $urandom_range(63, 0));
    push_dep($urandom_range(63, 0), $urandom_range(63, 0));
    push_build();
    queue_random_graph();
    wait_drained();

    // Random graphs, cycling through the idling phases.
    for (chunk = 0; chunk < 8; chunk++) begin
      set_idling(idle_phase_t'(chunk % 4));
      base = queued_items;
      while (queued_items - base < CHUNK_WORDS) queue_random_graph();
      wait_drained();
    end

    set_idling(IDLE_NONE);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d words over %0d random graphs; results: %0d ordered, %0d cycle,",
             words_sent, graphs_built, results_seen[dto_pkg::ST_ORDERED],
             results_seen[dto_pkg::ST_CYCLE]);
    $display("%0d empty, %0d rejected; store filled once and receiver held off once.",
             results_seen[dto_pkg::ST_EMPTY], results_seen[dto_pkg::ST_REJECT]);
    if (fail_count == 0) begin
      $display("dependency_topological_order verification clean");
    end else begin
      $display("dependency_topological_order verification failed");
    end
    $finish;
  end

endmodule
